>>> rtl/core/pms_pkg.sv
package pms_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int PRI_W    = 8;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = 2 + HANDLE_W + 1 + SLOT_W + HANDLE_W + 2 + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_SCAN,
    ST_DONE
  } pms_state_t;

endpackage

>>> rtl/core/priority_mode_stack.sv
// priority_mode_stack: stack of prioritized entries, removal by handle
// input channel (in_*): one transaction per operation. in_tuser is the opcode
// (push or pop), in_tdata carries the pushed priority, the handle to pop and
// the blend-enable flag. result channel (out_*): exactly one transaction per
// operation with status, the active entry after the operation, change and
// blend flags and the entry count.
// one operation at a time: in_tready is high only while the sequencer idles
// and comes back the cycle after a result is loaded into the output register.
// a push, a rejected push and a pop of handle 0 or on an empty stack go
// straight from acceptance to the done state. a pop that misses searches
// every entry from the top down. a pop that finds its handle runs a top-down
// search, a gap-closing move and a rescan for the active entry, one entry per
// cycle through the single read port of the entry store. popping the top entry
// skips the move, and popping the last entry also skips the rescan.
// the active entry is tracked in registers, so pushes need no scan.
// reset (rst_n low, synchronous) empties the stack and sets the next handle
// to 1; store contents are not cleared and need no clearing pass.
// a stalled result sits in the output register; the next operation is still
// taken and holds in its final state until that register frees up.
module priority_mode_stack (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // priority_req[7:0], handle_in[23:8], blend_enabled[24], zero pad
  input  logic [pms_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // ok[0], full_flag[1], handle_out[17:2], active_valid[18], active_slot[22:19],
  // active_handle[38:23], active_changed[39], start_blend[40],
  // entry_count[45:41], zero pad
  output logic [pms_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int IDXW = pms_pkg::IDX_W;
  localparam int CNTW = pms_pkg::CNT_W;
  localparam int HW   = pms_pkg::HANDLE_W;
  localparam int PW   = pms_pkg::PRI_W;

  // entry store
  logic [HW-1:0]        mem_h [pms_pkg::DEPTH];
  logic signed [PW-1:0] mem_p [pms_pkg::DEPTH];
  logic [HW-1:0]        rd_h_r;
  logic signed [PW-1:0] rd_p_r;
  logic [IDXW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IDXW-1:0]      wr_addr;
  logic [HW-1:0]        wr_h;
  logic signed [PW-1:0] wr_p;

  pms_pkg::pms_state_t  state_r, state_nxt;
  logic [CNTW-1:0]      count_r, count_nxt;
  logic [HW-1:0]        nhandle_r, nhandle_nxt;
  logic                 act_valid_r, act_valid_nxt;
  logic [IDXW-1:0]      act_slot_r, act_slot_nxt;
  logic [HW-1:0]        act_handle_r, act_handle_nxt;
  logic signed [PW-1:0] act_pri_r, act_pri_nxt;

  logic [IDXW-1:0]      ptr_r, ptr_nxt;
  logic [IDXW-1:0]      lim_r, lim_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDXW-1:0]      pidx_r, pidx_nxt;

  logic [HW-1:0]        hin_r, hin_nxt;
  logic                 blend_r, blend_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic                 res_full_r, res_full_nxt;
  logic [HW-1:0]        res_hout_r, res_hout_nxt;
  logic                 res_chg_r, res_chg_nxt;
  logic                 pop_ok_r, pop_ok_nxt;
  logic                 rem_act_r, rem_act_nxt;
  logic [IDXW-1:0]      oa_r, oa_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [pms_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                 in_acc;
  logic signed [PW-1:0] pri_in;
  logic [HW-1:0]        hin_in;
  logic                 chg;
  logic                 sblend;

  assign in_tready  = (state_r == pms_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign pri_in     = $signed(in_tdata[PW-1:0]);
  assign hin_in     = in_tdata[PW+HW-1:PW];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign rd_addr    = ptr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_h[wr_addr] <= wr_h;
      mem_p[wr_addr] <= wr_p;
    end
    rd_h_r <= mem_h[rd_addr];
    rd_p_r <= mem_p[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pms_pkg::ST_IDLE;
      count_r     <= '0;
      nhandle_r   <= HW'(1);
      act_valid_r <= 1'b0;
      act_slot_r  <= '0;
      act_handle_r <= '0;
      iss_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      nhandle_r   <= nhandle_nxt;
      act_valid_r <= act_valid_nxt;
      act_slot_r  <= act_slot_nxt;
      act_handle_r <= act_handle_nxt;
      iss_done_r  <= iss_done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_pri_r  <= act_pri_nxt;
    ptr_r      <= ptr_nxt;
    lim_r      <= lim_nxt;
    pidx_r     <= pidx_nxt;
    hin_r      <= hin_nxt;
    blend_r    <= blend_nxt;
    res_ok_r   <= res_ok_nxt;
    res_full_r <= res_full_nxt;
    res_hout_r <= res_hout_nxt;
    res_chg_r  <= res_chg_nxt;
    pop_ok_r   <= pop_ok_nxt;
    rem_act_r  <= rem_act_nxt;
    oa_r       <= oa_nxt;
    out_data_r <= out_data_nxt;
  end

  // final change flag: a pop compares the rescanned active entry with where
  // the old one ended up
  assign chg = pop_ok_r ? (rem_act_r || !act_valid_r || (act_slot_r != oa_r)) : res_chg_r;
  assign sblend = chg && act_valid_r && blend_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    nhandle_nxt    = nhandle_r;
    act_valid_nxt  = act_valid_r;
    act_slot_nxt   = act_slot_r;
    act_handle_nxt = act_handle_r;
    act_pri_nxt    = act_pri_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    iss_done_nxt   = iss_done_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    hin_nxt        = hin_r;
    blend_nxt      = blend_r;
    res_ok_nxt     = res_ok_r;
    res_full_nxt   = res_full_r;
    res_hout_nxt   = res_hout_r;
    res_chg_nxt    = res_chg_r;
    pop_ok_nxt     = pop_ok_r;
    rem_act_nxt    = rem_act_r;
    oa_nxt         = oa_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_h           = rd_h_r;
    wr_p           = rd_p_r;

    // shared read sequencer: issue one address per cycle, check its data from the registered read port
    if ((state_r == pms_pkg::ST_SEARCH || state_r == pms_pkg::ST_SHIFT ||
         state_r == pms_pkg::ST_SCAN) && !iss_done_r) begin
      pend_nxt = 1'b1;
      pidx_nxt = ptr_r;
      if (state_r == pms_pkg::ST_SEARCH) begin
        if (ptr_r == '0) iss_done_nxt = 1'b1;
        else ptr_nxt = ptr_r - 1'b1;
      end else begin
        if (ptr_r == lim_r) iss_done_nxt = 1'b1;
        else ptr_nxt = ptr_r + 1'b1;
      end
    end

    case (state_r)
      pms_pkg::ST_IDLE: begin
        if (in_acc) begin
          hin_nxt      = hin_in;
          blend_nxt    = in_tdata[PW+HW];
          res_ok_nxt   = 1'b0;
          res_full_nxt = 1'b0;
          res_hout_nxt = '0;
          res_chg_nxt  = 1'b0;
          pop_ok_nxt   = 1'b0;
          rem_act_nxt  = 1'b0;
          state_nxt    = pms_pkg::ST_DONE;
          if (in_tuser == pms_pkg::OP_PUSH) begin
            if (count_r == CNTW'(pms_pkg::DEPTH)) begin
              res_full_nxt = 1'b1;
            end else begin
              wr_en        = 1'b1;
              wr_addr      = count_r[IDXW-1:0];
              wr_h         = nhandle_r;
              wr_p         = pri_in;
              count_nxt    = count_r + 1'b1;
              nhandle_nxt  = (nhandle_r == {HW{1'b1}}) ? HW'(1) : nhandle_r + 1'b1;
              res_ok_nxt   = 1'b1;
              res_hout_nxt = nhandle_r;
              // ties go to the newer entry
              if (!act_valid_r || (pri_in >= act_pri_r)) begin
                act_valid_nxt  = 1'b1;
                act_slot_nxt   = count_r[IDXW-1:0];
                act_handle_nxt = nhandle_r;
                act_pri_nxt    = pri_in;
                res_chg_nxt    = 1'b1;
              end
            end
          end else if ((hin_in != '0) && (count_r != '0)) begin
            ptr_nxt      = IDXW'(count_r - 1'b1);
            iss_done_nxt = 1'b0;
            state_nxt    = pms_pkg::ST_SEARCH;
          end
        end
      end

      pms_pkg::ST_SEARCH: begin
        if (pend_r) begin
          if (rd_h_r == hin_r) begin
            count_nxt    = count_r - 1'b1;
            res_ok_nxt   = 1'b1;
            res_hout_nxt = hin_r;
            pop_ok_nxt   = 1'b1;
            rem_act_nxt  = (pidx_r == act_slot_r);
            oa_nxt       = (pidx_r < act_slot_r) ? act_slot_r - 1'b1 : act_slot_r;
            pend_nxt     = 1'b0;
            iss_done_nxt = 1'b0;
            if (pidx_r == IDXW'(count_r - 1'b1)) begin
              // topmost entry removed, nothing to move
              if (count_r == CNTW'(1)) begin
                act_valid_nxt  = 1'b0;
                act_slot_nxt   = '0;
                act_handle_nxt = '0;
                state_nxt      = pms_pkg::ST_DONE;
              end else begin
                ptr_nxt   = '0;
                lim_nxt   = IDXW'(count_r - CNTW'(2));
                state_nxt = pms_pkg::ST_SCAN;
              end
            end else begin
              ptr_nxt   = pidx_r + 1'b1;
              lim_nxt   = IDXW'(count_r - 1'b1);
              state_nxt = pms_pkg::ST_SHIFT;
            end
          end else if (pidx_r == '0) begin
            pend_nxt  = 1'b0;
            state_nxt = pms_pkg::ST_DONE;
          end
        end
      end

      pms_pkg::ST_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r - 1'b1;
          if (pidx_r == lim_r) begin
            pend_nxt     = 1'b0;
            iss_done_nxt = 1'b0;
            ptr_nxt      = '0;
            lim_nxt      = IDXW'(count_r - 1'b1);
            state_nxt    = pms_pkg::ST_SCAN;
          end
        end
      end

      pms_pkg::ST_SCAN: begin
        if (pend_r) begin
          if ((pidx_r == '0) || (rd_p_r >= act_pri_r)) begin
            act_valid_nxt  = 1'b1;
            act_slot_nxt   = pidx_r;
            act_handle_nxt = rd_h_r;
            act_pri_nxt    = rd_p_r;
          end
          if (pidx_r == lim_r) begin
            pend_nxt  = 1'b0;
            state_nxt = pms_pkg::ST_DONE;
          end
        end
      end

      pms_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {
            (pms_pkg::OUT_TDATA_W - pms_pkg::OUT_FIELD_W)'(0),
            pms_pkg::COUNT_W'(count_r),
            sblend,
            chg,
            act_valid_r ? act_handle_r : HW'(0),
            act_valid_r ? pms_pkg::SLOT_W'(act_slot_r) : pms_pkg::SLOT_W'(0),
            act_valid_r,
            res_hout_r,
            res_full_r,
            res_ok_r
          };
          state_nxt = pms_pkg::ST_IDLE;
        end
      end

      default: state_nxt = pms_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/pms_chk.sv
module pms_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pms_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pms_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one operation at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new transaction taken while busy");

  // a successful operation always names a real handle
  a_ok_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[17:2] != 16'd0)
    else $error("ok with handle zero");

  // a rejected push only happens on a full stack
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |->
      !out_tdata[0] && !out_tdata[39] &&
      out_tdata[45:41] == pms_pkg::COUNT_W'(pms_pkg::DEPTH))
    else $error("full flag on a stack that is not full");

  a_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[40] |-> out_tdata[39] && out_tdata[18])
    else $error("blend without a new active entry");

endmodule

bind priority_mode_stack pms_chk u_pms_chk (.*);

>>> tb/priority_mode_stack_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic                         ok;
  logic                         full_flag;
  logic [pms_pkg::HANDLE_W-1:0] handle_out;
  logic                         active_valid;
  logic [pms_pkg::SLOT_W-1:0]   active_slot;
  logic [pms_pkg::HANDLE_W-1:0] active_handle;
  logic                         active_changed;
  logic                         start_blend;
  logic [pms_pkg::COUNT_W-1:0]  entry_count;
} stack_result_t;

// mirror of the entry stack plus the queue of results still to come
class stack_tracker;
  logic [pms_pkg::HANDLE_W-1:0]     handles [pms_pkg::DEPTH];
  logic signed [pms_pkg::PRI_W-1:0] prios [pms_pkg::DEPTH];
  int                               count;
  logic [pms_pkg::HANDLE_W-1:0]     next_handle;
  stack_result_t                    pending_results [$];
  int                               errors;

  function new();
    count = 0;
    next_handle = pms_pkg::HANDLE_W'(1);
    errors = 0;
  endfunction

  // highest priority wins, ties go to the higher position; -1 when empty
  function int active_pos();
    int best;
    best = -1;
    for (int i = 0; i < count; i++) begin
      if (best < 0 || prios[i] >= prios[best]) best = i;
    end
    return best;
  endfunction

  function void note_op(logic op, logic [pms_pkg::PRI_W-1:0] pri,
                        logic [pms_pkg::HANDLE_W-1:0] hin, logic blend);
    stack_result_t r;
    int old_act, old_after, new_act, found;
    r = '0;
    old_act = active_pos();
    old_after = old_act;
    if (op == pms_pkg::OP_PUSH) begin
      if (count >= pms_pkg::DEPTH) begin
        r.full_flag = 1'b1;
      end else begin
        handles[count] = next_handle;
        prios[count] = pri;
        count++;
        r.ok = 1'b1;
        r.handle_out = next_handle;
        next_handle = (next_handle == '1) ? pms_pkg::HANDLE_W'(1) : next_handle + 1'b1;
      end
    end else if (hin != 0) begin
      found = -1;
      for (int i = count - 1; i >= 0 && found < 0; i--) begin
        if (handles[i] == hin) found = i;
      end
      if (found >= 0) begin
        for (int k = found; k < count - 1; k++) begin
          handles[k] = handles[k + 1];
          prios[k] = prios[k + 1];
        end
        count--;
        r.ok = 1'b1;
        r.handle_out = hin;
        // follow the old active entry across the gap
        if (old_act >= 0) begin
          if (found == old_act) old_after = -1;
          else if (found < old_act) old_after = old_act - 1;
        end
      end
    end
    new_act = active_pos();
    if (r.ok && (new_act != old_after ||
        (op == pms_pkg::OP_POP && old_act >= 0 && old_after < 0 && new_act >= 0)))
      r.active_changed = 1'b1;
    if (r.ok && old_after < 0 && new_act < 0 && old_act >= 0)
      r.active_changed = 1'b1;
    r.active_valid = (new_act >= 0);
    r.active_slot = (new_act >= 0) ? pms_pkg::SLOT_W'(new_act) : '0;
    r.active_handle = (new_act >= 0) ? handles[new_act] : '0;
    r.start_blend = r.active_changed && (new_act >= 0) && blend;
    r.entry_count = pms_pkg::COUNT_W'(count);
    pending_results.push_back(r);
  endfunction

  task report(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_field(string name, logic [pms_pkg::HANDLE_W-1:0] got,
                   logic [pms_pkg::HANDLE_W-1:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task check_result(logic [pms_pkg::OUT_TDATA_W-1:0] d);
    stack_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0h with no transaction pending", d));
    end else begin
      want = pending_results.pop_front();
      check_field("ok", pms_pkg::HANDLE_W'(d[0]), pms_pkg::HANDLE_W'(want.ok));
      check_field("full_flag", pms_pkg::HANDLE_W'(d[1]),
                  pms_pkg::HANDLE_W'(want.full_flag));
      check_field("handle_out", d[17:2], want.handle_out);
      check_field("active_valid", pms_pkg::HANDLE_W'(d[18]),
                  pms_pkg::HANDLE_W'(want.active_valid));
      check_field("active_slot", pms_pkg::HANDLE_W'(d[22:19]),
                  pms_pkg::HANDLE_W'(want.active_slot));
      check_field("active_handle", d[38:23], want.active_handle);
      check_field("active_changed", pms_pkg::HANDLE_W'(d[39]),
                  pms_pkg::HANDLE_W'(want.active_changed));
      check_field("start_blend", pms_pkg::HANDLE_W'(d[40]),
                  pms_pkg::HANDLE_W'(want.start_blend));
      check_field("entry_count", pms_pkg::HANDLE_W'(d[45:41]),
                  pms_pkg::HANDLE_W'(want.entry_count));
    end
  endtask
endclass

module priority_mode_stack_tb;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pms_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = pms_pkg::OP_PUSH;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pms_pkg::OUT_TDATA_W-1:0] out_tdata;

  int in_idle_pct = 0;
  int out_idle_pct = 0;

  stack_tracker sb = new();

  priority_mode_stack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_op(logic op, logic [pms_pkg::PRI_W-1:0] pri,
                         logic [pms_pkg::HANDLE_W-1:0] hin, logic blend);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'b0, blend, hin, pri};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(op, pri, hin, blend);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic run_directed();
    send_op(pms_pkg::OP_POP, 8'h00, 16'd1, 1'b1);      // empty stack, nothing to find
    send_op(pms_pkg::OP_POP, 8'h7F, 16'd0, 1'b0);      // invalid handle on empty stack
    send_op(pms_pkg::OP_PUSH, 8'h80, 16'hFFFF, 1'b1);  // handle_in is don't-care on push
    send_op(pms_pkg::OP_PUSH, 8'h7F, 16'h0000, 1'b0);
    send_op(pms_pkg::OP_PUSH, 8'h7F, 16'hA5A5, 1'b1);  // tie, the later entry takes over
    send_op(pms_pkg::OP_PUSH, 8'h00, 16'h5A5A, 1'b1);
    send_op(pms_pkg::OP_POP, 8'h80, 16'd0, 1'b1);
    send_op(pms_pkg::OP_POP, 8'h00, 16'hFFFF, 1'b1);
    send_op(pms_pkg::OP_POP, 8'hFF, 16'd3, 1'b1);      // removes the active entry
    send_op(pms_pkg::OP_POP, 8'h01, 16'd1, 1'b0);      // removes an entry below the active one
    for (int i = 0; i < 14; i++)
      send_op(pms_pkg::OP_PUSH,
              (i % 3 == 0) ? 8'h80 : (i % 3 == 1) ? 8'h7F : pms_pkg::PRI_W'(i),
              pms_pkg::HANDLE_W'(i), 1'(i));
    send_op(pms_pkg::OP_PUSH, 8'h55, 16'h0000, 1'b1);  // stack full
  endtask

  task automatic random_ops(int n);
    int push_pct;
    int r;
    logic [pms_pkg::PRI_W-1:0] pri;
    logic [pms_pkg::HANDLE_W-1:0] hin;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      // swing between filling and emptying so both ends are reached
      if (i % 40 == 0) push_pct = $urandom_range(1) ? 70 : 30;
      r = $urandom_range(99);
      if (r < 40) pri = pms_pkg::PRI_W'($urandom_range(4) - 2);
      else if (r < 50) pri = $urandom_range(1) ? 8'h7F : 8'h80;
      else pri = pms_pkg::PRI_W'($urandom);
      r = $urandom_range(99);
      if (r < 75 && sb.count > 0) hin = sb.handles[$urandom_range(sb.count - 1)];
      else if (r < 85) hin = '0;
      else hin = pms_pkg::HANDLE_W'($urandom);
      if ($urandom_range(99) < ((sb.count == 0) ? 85 : push_pct))
        send_op(pms_pkg::OP_PUSH, pri, pms_pkg::HANDLE_W'($urandom), 1'($urandom));
      else
        send_op(pms_pkg::OP_POP, pri, hin, 1'($urandom));
    end
  endtask

  initial begin
    in_idle_pct = 23;
    out_idle_pct = 75;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    random_ops(430);
    drain_results();
    in_idle_pct = 75;
    out_idle_pct = 23;
    random_ops(430);
    drain_results();
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_ops(440);
    drain_results();
    repeat (100) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("[priority_mode_stack] OK");
    end else begin
      $display("[priority_mode_stack] ERROR");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("[priority_mode_stack] ERROR");
    $finish;
  end

endmodule

>>> priority_mode_stack.f
rtl/core/pms_pkg.sv
rtl/core/priority_mode_stack.sv
rtl/core/pms_chk.sv
tb/priority_mode_stack_tb.sv
